@@ src/evod_pkg.sv @@
// ----------------------------------------------------------------------------
// evod_pkg
// Shared widths, register codes, config struct and dither table for the
// edge vignette ordered dither block.
// ----------------------------------------------------------------------------
`default_nettype none

package evod_pkg;

	localparam int MARGIN = 70;

	localparam int X_W     = 12;
	localparam int Y_W     = 12;
	localparam int COLOR_W = 24;
	localparam int CH_W    = 8;
	localparam int SEV_W   = 9;
	localparam int FACT_W  = 9;
	localparam int DIM_W   = 13;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_ADDR_W-1:0] REG_SEVERITY      = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DARKEN_FACTOR = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

	localparam logic [SEV_W-1:0]  SEVERITY_RST      = 9'd0;
	localparam logic [FACT_W-1:0] DARKEN_FACTOR_RST = 9'd115;
	localparam logic [DIM_W-1:0]  SCREEN_WIDTH_RST  = 13'd320;
	localparam logic [DIM_W-1:0]  SCREEN_HEIGHT_RST = 13'd240;

	localparam int SEV_MAX = 256;
	localparam int DIST_W  = $clog2(MARGIN + 1);
	localparam int PROD_W  = $clog2(MARGIN * SEV_MAX + 1);
	localparam int LVL_W   = 4;

	localparam logic [LVL_W-1:0] BAYER [4][4] = '{
		'{4'd0,  4'd8,  4'd2,  4'd10},
		'{4'd12, 4'd4,  4'd14, 4'd6},
		'{4'd3,  4'd11, 4'd1,  4'd9},
		'{4'd15, 4'd7,  4'd13, 4'd5}
	};

	typedef struct packed {
		logic [SEV_W-1:0]  severity;
		logic [FACT_W-1:0] darken_factor;
		logic [DIM_W-1:0]  screen_width;
		logic [DIM_W-1:0]  screen_height;
	} cfg_t;

	// threshold > level  <=>  (MARGIN - dist) * sev >= (level + 1) * MARGIN * 16
	function automatic logic [PROD_W-1:0] dither_limit(input logic [LVL_W-1:0] level);
		dither_limit = PROD_W'((int'(level) + 1) * MARGIN * 16);
	endfunction

endpackage

`default_nettype wire

@@ src/edge_vignette_ordered_dither.sv @@
// ----------------------------------------------------------------------------
// edge_vignette_ordered_dither
// Darkens pixels near the screen border through a 4x4 ordered dither.
// ----------------------------------------------------------------------------
//
// channel   dir  request contents
// s_axis    in   tdata: pixel_x [11:0], pixel_y [23:12], pixel_color [47:24]
// m_axis    out  tdata: color_out [23:0]; tuser: darkened
// cfg       in   cfg_addr selects register, cfg_wdata value, cfg_we strobe
//
// one pixel per clock sustained while the output is not stalled
// input register feeds one combinational pass into the result register
// a stalled result holds; the input register still takes a pixel while empty
// reset clears both valid flags and loads the register reset values
//
`default_nettype none

module edge_vignette_ordered_dither (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [evod_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // pixel_x, pixel_y, pixel_color
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic      [evod_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // color_out
	output logic                                     m_axis_tuser,  // darkened
	input  wire logic                                cfg_we,
	input  wire logic [evod_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [evod_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import evod_pkg::*;

	cfg_t cfg_q;

	logic               valid_s1;
	logic [X_W-1:0]     x_s1;
	logic [Y_W-1:0]     y_s1;
	logic [COLOR_W-1:0] color_s1;

	logic               valid_s2;
	logic [COLOR_W-1:0] color_s2;
	logic               dark_s2;

	logic               advance;
	logic               dark;
	logic [COLOR_W-1:0] color_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.severity      <= SEVERITY_RST;
			cfg_q.darken_factor <= DARKEN_FACTOR_RST;
			cfg_q.screen_width  <= SCREEN_WIDTH_RST;
			cfg_q.screen_height <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SEVERITY:      cfg_q.severity      <= cfg_wdata[SEV_W-1:0];
				REG_DARKEN_FACTOR: cfg_q.darken_factor <= cfg_wdata[FACT_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata[DIM_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[DIM_W-1:0];
			endcase
		end
	end

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			x_s1     <= s_axis_tdata[X_W-1:0];
			y_s1     <= s_axis_tdata[X_W +: Y_W];
			color_s1 <= s_axis_tdata[X_W+Y_W +: COLOR_W];
		end
		if (advance && valid_s1) begin
			color_s2 <= dark ? color_scaled : color_s1;
			dark_s2  <= dark;
		end
	end

	evod_border u_border (
		.pixel_x (x_s1),
		.pixel_y (y_s1),
		.cfg     (cfg_q),
		.dark    (dark)
	);

	evod_scale u_scale (
		.color        (color_s1),
		.factor       (cfg_q.darken_factor),
		.color_scaled (color_scaled)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = color_s2;
	assign m_axis_tuser  = dark_s2;

endmodule

`default_nettype wire

@@ src/evod_border.sv @@
// ----------------------------------------------------------------------------
// evod_border
// Border distance, clamped severity and dither compare for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module evod_border (
	input  wire logic [evod_pkg::X_W-1:0] pixel_x,
	input  wire logic [evod_pkg::Y_W-1:0] pixel_y,
	input  wire evod_pkg::cfg_t           cfg,
	output logic                          dark
);
	import evod_pkg::*;

	logic             on_screen;
	logic [DIM_W-1:0] x_ext;
	logic [DIM_W-1:0] y_ext;
	logic [DIM_W-1:0] dist_right;
	logic [DIM_W-1:0] dist_bottom;
	logic [DIM_W-1:0] dist_h;
	logic [DIM_W-1:0] dist_v;
	logic [DIM_W-1:0] dist_min;
	logic             near;
	logic [DIST_W-1:0] depth;
	logic [SEV_W-1:0]  sev;
	logic [PROD_W-1:0] strength;
	logic [LVL_W-1:0]  level;

	assign x_ext = DIM_W'(pixel_x);
	assign y_ext = DIM_W'(pixel_y);

	assign on_screen = (x_ext < cfg.screen_width) && (y_ext < cfg.screen_height);

	// only meaningful when on screen
	assign dist_right  = cfg.screen_width - DIM_W'(1) - x_ext;
	assign dist_bottom = cfg.screen_height - DIM_W'(1) - y_ext;

	assign dist_h   = (dist_right < x_ext) ? dist_right : x_ext;
	assign dist_v   = (dist_bottom < y_ext) ? dist_bottom : y_ext;
	assign dist_min = (dist_v < dist_h) ? dist_v : dist_h;

	assign near  = dist_min < DIM_W'(MARGIN);
	assign depth = DIST_W'(DIM_W'(MARGIN) - dist_min);

	assign sev = (cfg.severity > SEV_W'(SEV_MAX)) ? SEV_W'(SEV_MAX) : cfg.severity;

	assign strength = PROD_W'(depth) * PROD_W'(sev);
	assign level    = BAYER[pixel_y[1:0]][pixel_x[1:0]];

	assign dark = on_screen && near && (strength >= dither_limit(level));

endmodule

`default_nettype wire

@@ src/evod_scale.sv @@
// ----------------------------------------------------------------------------
// evod_scale
// Scales the three color channels by a Q1.8 factor, saturating at full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module evod_scale (
	input  wire logic [evod_pkg::COLOR_W-1:0] color,
	input  wire logic [evod_pkg::FACT_W-1:0]  factor,
	output logic      [evod_pkg::COLOR_W-1:0] color_scaled
);
	import evod_pkg::*;

	localparam int MUL_W = CH_W + FACT_W;

	for (genvar i = 0; i < 3; i++) begin : g_ch
		logic [MUL_W-1:0]  mul;
		logic [FACT_W-1:0] shifted;

		assign mul     = MUL_W'(color[i*CH_W +: CH_W]) * MUL_W'(factor);
		assign shifted = mul[MUL_W-1:CH_W];
		assign color_scaled[i*CH_W +: CH_W] =
			(shifted > FACT_W'(255)) ? 8'hFF : shifted[CH_W-1:0];
	end

endmodule

`default_nettype wire

@@ src/evod_checker.sv @@
// ----------------------------------------------------------------------------
// evod_checker
// Port-level checks of the stream handshake and pipeline timing.
// ----------------------------------------------------------------------------
`default_nettype none

module evod_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [evod_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                            m_axis_tuser
);

	// no result straight out of reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid right after reset");

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// input only back-pressured when the result side is full and stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// a fresh result follows a request accepted through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching request");

endmodule

bind edge_vignette_ordered_dither evod_checker u_evod_checker (.*);

`default_nettype wire
